// ----- hw/rtl/tihex_pkg.sv -----
// tihex_pkg: shared types and character codes for the TI-TXT record parser.
// No dependencies; imported by every module of the parser.
`timescale 1ns / 1ps

package tihex_pkg;

    localparam logic [7:0]  CH_CR    = 8'h0D;
    localparam logic [7:0]  CH_LF    = 8'h0A;
    localparam logic [7:0]  CH_SPACE = 8'h20;
    localparam logic [7:0]  CH_AT    = 8'h40;
    localparam logic [7:0]  CH_Q     = 8'h71;
    localparam logic [23:0] LINE_MAX = 24'hFF_FFFF;
    localparam logic [31:0] ADDR_ALL_ONES = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ST_WRITE = 2'd0,
        ST_DONE  = 2'd1,
        ST_ERROR = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CMD_DIGIT,
        CMD_NEWLINE,
        CMD_SPACE,
        CMD_MARK,
        CMD_QUIT,
        CMD_END,
        CMD_BAD
    } cmd_kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] write_address;
        logic [31:0] write_value;
        logic [23:0] line_number;
        logic [31:0] lowest_address;
        logic [31:0] highest_address;
        logic        last_result;
    } out_item_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [3:0] digit;
    } cmd_t;

    typedef struct packed {
        logic stopped;
    } back_stat_t;

endpackage

// ----- hw/rtl/tihex_front.sv -----
// tihex_front: classifies one input byte into a parser command; CR is not kept.
// Depends on tihex_pkg.
`timescale 1ns / 1ps

module tihex_front
(
    input  tihex_pkg::in_item_t item,
    output logic                keep,
    output tihex_pkg::cmd_t     cmd
);
    import tihex_pkg::*;

    logic [7:0] b;

    assign b = item.data_byte;

    always_comb
    begin
        keep      = 1'b1;
        cmd.digit = b[3:0];
        cmd.kind  = CMD_BAD;
        if (item.end_of_input)
        begin
            cmd.kind = CMD_END;
        end
        else if (b == CH_CR)
        begin
            keep = 1'b0;
        end
        else if (b == CH_LF)
        begin
            cmd.kind = CMD_NEWLINE;
        end
        else if (b == CH_SPACE)
        begin
            cmd.kind = CMD_SPACE;
        end
        else if (b == CH_AT)
        begin
            cmd.kind = CMD_MARK;
        end
        else if (b == CH_Q)
        begin
            cmd.kind = CMD_QUIT;
        end
        else if (b >= 8'h30 && b <= 8'h39)
        begin
            cmd.kind = CMD_DIGIT;
        end
        else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66))
        begin
            cmd.kind  = CMD_DIGIT;
            cmd.digit = b[3:0] + 4'd9;
        end
    end

endmodule

// ----- hw/rtl/tihex_queue.sv -----
// tihex_queue: small command FIFO between the front and back of the parser.
// Depends on tihex_pkg.
`timescale 1ns / 1ps

module tihex_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tihex_pkg::cmd_t push_cmd,
    output logic            full,
    output logic            head_valid,
    output tihex_pkg::cmd_t head_cmd,
    input  logic            pop
);
    import tihex_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    cmd_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- hw/rtl/tihex_back.sv -----
// tihex_back: executes parser commands, holds token/address state and the
// result register. Depends on tihex_pkg.
`timescale 1ns / 1ps

module tihex_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    input  tihex_pkg::cmd_t       cmd,
    output logic                  pop,
    output tihex_pkg::out_item_t  res_item,
    output logic                  res_valid,
    input  logic                  res_ready,
    output tihex_pkg::back_stat_t stat
);
    import tihex_pkg::*;

    logic [31:0] acc_reg, acc_next;
    logic        dig_reg, dig_next;
    logic        mark_reg, mark_next;
    logic [31:0] load_reg, load_next;
    logic [31:0] min_reg, min_next;
    logic [31:0] max_reg, max_next;
    logic [23:0] line_reg, line_next;
    logic        stopped_reg, stopped_next;
    logic        out_valid_reg;
    out_item_t   out_reg;

    logic        emit, last, hold, go, slot_free, do_complete;
    status_t     st;
    logic [31:0] w_addr, w_val;
    out_item_t   res;

    assign slot_free = !out_valid_reg || res_ready;

    always_comb
    begin
        acc_next     = acc_reg;
        dig_next     = dig_reg;
        mark_next    = mark_reg;
        load_next    = load_reg;
        min_next     = min_reg;
        max_next     = max_reg;
        line_next    = line_reg;
        stopped_next = stopped_reg;
        emit         = 1'b0;
        last         = 1'b1;
        hold         = 1'b0;
        do_complete  = 1'b0;
        st           = ST_DONE;
        w_addr       = '0;
        w_val        = '0;

        case (cmd.kind)
            CMD_DIGIT:
            begin
                acc_next = {acc_reg[27:0], cmd.digit};
                dig_next = 1'b1;
            end
            CMD_NEWLINE:
            begin
                if (line_reg < LINE_MAX)
                begin
                    line_next = line_reg + 24'd1;
                end
                do_complete = dig_reg;
            end
            CMD_SPACE:
            begin
                do_complete = dig_reg;
            end
            CMD_MARK:
            begin
                mark_next = 1'b1;
            end
            CMD_QUIT:
            begin
                acc_next     = '0;
                dig_next     = 1'b0;
                mark_next    = 1'b0;
                emit         = 1'b1;
                stopped_next = 1'b1;
            end
            CMD_END:
            begin
                if (dig_reg)
                begin
                    do_complete = 1'b1;
                    hold        = 1'b1;
                    last        = 1'b0;
                end
                else
                begin
                    emit         = 1'b1;
                    stopped_next = 1'b1;
                end
            end
            CMD_BAD:
            begin
                emit         = 1'b1;
                st           = ST_ERROR;
                stopped_next = 1'b1;
            end
            default:
            begin
            end
        endcase

        if (do_complete)
        begin
            acc_next  = '0;
            dig_next  = 1'b0;
            mark_next = 1'b0;
            if (mark_reg)
            begin
                load_next = acc_reg;
            end
            else
            begin
                emit      = 1'b1;
                st        = ST_WRITE;
                w_addr    = load_reg;
                w_val     = acc_reg;
                load_next = load_reg + 32'd1;
                if (load_reg < min_reg)
                begin
                    min_next = load_reg;
                end
                if (load_reg > max_reg)
                begin
                    max_next = load_reg;
                end
            end
        end

        res.status          = st;
        res.write_address   = w_addr;
        res.write_value     = w_val;
        res.line_number     = line_next;
        res.lowest_address  = min_next;
        res.highest_address = max_next;
        res.last_result     = last;

        go  = cmd_valid && (stopped_reg || !emit || slot_free);
        pop = go && (stopped_reg || !hold);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            dig_reg       <= 1'b0;
            mark_reg      <= 1'b0;
            load_reg      <= '0;
            min_reg       <= ADDR_ALL_ONES;
            max_reg       <= '0;
            line_reg      <= 24'd1;
            stopped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (go && !stopped_reg)
            begin
                acc_reg     <= acc_next;
                dig_reg     <= dig_next;
                mark_reg    <= mark_next;
                load_reg    <= load_next;
                min_reg     <= min_next;
                max_reg     <= max_next;
                line_reg    <= line_next;
                stopped_reg <= stopped_next;
            end
            if (go && !stopped_reg && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && !stopped_reg && emit)
        begin
            out_reg <= res;
        end
    end

    assign res_item     = out_reg;
    assign res_valid    = out_valid_reg;
    assign stat.stopped = stopped_reg;

endmodule

// ----- hw/rtl/ti_txt_hex_record_parser.sv -----
// ti_txt_hex_record_parser: top level of the TI-TXT record parser.
// Depends on tihex_pkg, tihex_front, tihex_queue, tihex_back.
//
//   channel | valid     | ready     | payload
//   --------+-----------+-----------+-----------------------
//   source  | src_valid | src_ready | src_item  (in_item_t)
//   result  | res_valid | res_ready | res_item  (out_item_t)
//
// One byte per cycle while the FIFO has room; the back end retires a command
// a cycle unless a result waits on res_ready. End of input with a pending
// token gives its write result (none for an address), then a done result.
// src_ready drops only when the QUEUE_DEPTH command FIFO is full.
// After a done or error result, transfers are taken and dropped until reset.
`timescale 1ns / 1ps

module ti_txt_hex_record_parser
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 src_valid,
    output logic                 src_ready,
    input  tihex_pkg::in_item_t  src_item,
    output logic                 res_valid,
    input  logic                 res_ready,
    output tihex_pkg::out_item_t res_item
);
    import tihex_pkg::*;

    logic       keep, q_full, q_valid, q_pop;
    cmd_t       f_cmd, q_cmd;
    back_stat_t stat;

    assign src_ready = !q_full;

    tihex_front u_front
    (
        .item (src_item),
        .keep (keep),
        .cmd  (f_cmd)
    );

    tihex_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (src_valid && keep),
        .push_cmd   (f_cmd),
        .full       (q_full),
        .head_valid (q_valid),
        .head_cmd   (q_cmd),
        .pop        (q_pop)
    );

    tihex_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd       (q_cmd),
        .pop       (q_pop),
        .res_item  (res_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .stat      (stat)
    );

    a_final_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.status != ST_WRITE |-> res_item.last_result)
        else $error("done/error result not marked last");

    a_final_stops: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.status != ST_WRITE |-> stat.stopped)
        else $error("done/error result without stop");

    a_range_covers: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.status == ST_WRITE |->
        res_item.lowest_address <= res_item.write_address &&
        res_item.highest_address >= res_item.write_address)
        else $error("write address outside tracked range");

    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        stat.stopped |=> stat.stopped)
        else $error("stop flag cleared");

endmodule
